// ===== hdl/ttrq_pkg.sv =====
`default_nettype none

package ttrq_pkg;

  localparam int QueueDepthDefault = 16;
  localparam int MaxResults = 16;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_RELEASED = 2'd2;

  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] due;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_REJ,
    ST_TICK_RD,
    ST_TICK_CMP,
    ST_TICK_END
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/ttrq_store.sv =====
`default_nettype none

module ttrq_store #(
  parameter int DEPTH = ttrq_pkg::QueueDepthDefault
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ttrq_pkg::entry_t         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ttrq_pkg::entry_t         rd_data
);
  import ttrq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/timed_task_release_queue_top.sv =====
`default_nettype none

// Channel | Direction | Handshake                      | Beat fields
// in      | input     | in_valid / in_stall (driven)   | opcode, task_handle, time_value
// out     | output    | out_valid / out_stall (input)  | result_kind, released_handle,
//         |           |                                | released_due_time, last_of_run
//
// Entries sit sorted in a circular buffer in a simple dual-port memory with a registered read.
// An add shifts each later pending entry up one place, then writes the new entry into the gap;
// a rejected add only returns a rejected beat. A tick releases due tasks from the head; each
// entry examined goes through the memory read and the one shared due-time comparator.
// Synchronous active-low reset empties the queue; the memory itself is not cleared.
// A stalled output stalls only the states that emit a beat; new beats are taken only when idle.

module timed_task_release_queue_top #(
  parameter int QUEUE_DEPTH = ttrq_pkg::QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_task_handle,
  input  logic [31:0] in_time_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_released_handle,
  output logic [31:0] out_released_due_time,
  output logic        out_last_of_run
);
  import ttrq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(QUEUE_DEPTH - 1) : p - AW'(1);
  endfunction

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          held_v_r, held_v_nxt;
  entry_t        held_r, held_nxt;
  logic [7:0]    handle_r, handle_nxt;
  logic [31:0]   time_r, time_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [7:0]    out_handle_r, out_handle_nxt;
  logic [31:0]   out_due_r, out_due_nxt;
  logic          out_last_r, out_last_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  entry_t        wr_data, rd_data;
  logic          out_free, due_le;

  ttrq_store #(.DEPTH(QUEUE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign due_le   = (rd_data.due <= time_r);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    n_nxt          = n_r;
    held_v_nxt     = held_v_r;
    held_nxt       = held_r;
    handle_nxt     = handle_r;
    time_nxt       = time_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_handle_nxt = out_handle_r;
    out_due_nxt    = out_due_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = ptr_r;
    wr_data        = rd_data;
    rd_en          = 1'b0;
    rd_addr        = ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          handle_nxt = in_task_handle;
          time_nxt   = in_time_value;
          if (in_opcode == OP_ADD) begin
            if (int'(count_r) == QUEUE_DEPTH) begin
              state_nxt = ST_REJ;
            end else begin
              ptr_nxt   = tail_r;
              n_nxt     = count_r;
              state_nxt = ST_ADD_RD;
            end
          end else begin
            ptr_nxt    = head_r;
            n_nxt      = '0;
            held_v_nxt = 1'b0;
            state_nxt  = ST_TICK_RD;
          end
        end
      end
      ST_ADD_RD: begin
        if (n_r == '0) begin
          state_nxt = ST_ADD_PUT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr_dec(ptr_r);
          state_nxt = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        if (!due_le) begin
          wr_en     = 1'b1;
          ptr_nxt   = ptr_dec(ptr_r);
          n_nxt     = n_r - CW'(1);
          state_nxt = ST_ADD_RD;
        end else begin
          state_nxt = ST_ADD_PUT;
        end
      end
      ST_ADD_PUT: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_data.handle = handle_r;
          wr_data.due    = time_r;
          tail_nxt       = ptr_inc(tail_r);
          count_nxt      = count_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_ACCEPTED;
          out_handle_nxt = handle_r;
          out_due_nxt    = time_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_REJ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_REJECTED;
          out_handle_nxt = handle_r;
          out_due_nxt    = time_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_TICK_RD: begin
        if (n_r < count_r && int'(n_r) < MaxResults) begin
          rd_en     = 1'b1;
          state_nxt = ST_TICK_CMP;
        end else begin
          state_nxt = ST_TICK_END;
        end
      end
      ST_TICK_CMP: begin
        if (!due_le) begin
          state_nxt = ST_TICK_END;
        end else if (!held_v_r || out_free) begin
          if (held_v_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = KIND_RELEASED;
            out_handle_nxt = held_r.handle;
            out_due_nxt    = held_r.due;
            out_last_nxt   = 1'b0;
          end
          held_nxt   = rd_data;
          held_v_nxt = 1'b1;
          n_nxt      = n_r + CW'(1);
          ptr_nxt    = ptr_inc(ptr_r);
          state_nxt  = ST_TICK_RD;
        end
      end
      ST_TICK_END: begin
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_RELEASED;
          out_handle_nxt = held_r.handle;
          out_due_nxt    = held_r.due;
          out_last_nxt   = 1'b1;
          held_v_nxt     = 1'b0;
          head_nxt       = ptr_r;
          count_nxt      = count_r - n_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      ptr_r       <= '0;
      count_r     <= '0;
      n_r         <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r       <= held_nxt;
    handle_r     <= handle_nxt;
    time_r       <= time_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_due_r    <= out_due_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_released_handle   = out_handle_r;
  assign out_released_due_time = out_due_r;
  assign out_last_of_run       = out_last_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QUEUE_DEPTH)
    else $error("pending count exceeds queue depth");

  a_held_only_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    held_v_r |-> (state_r == ST_TICK_RD || state_r == ST_TICK_CMP ||
                  state_r == ST_TICK_END))
    else $error("held release entry outside a tick");

  a_release_within_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK_RD || state_r == ST_TICK_CMP || state_r == ST_TICK_END)
      |-> (n_r <= count_r && int'(n_r) <= MaxResults))
    else $error("release count beyond pending entries or run limit");

  a_full_add_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_opcode == OP_ADD && int'(count_r) == QUEUE_DEPTH)
      |=> state_r == ST_REJ)
    else $error("add to a full queue not rejected");

  a_stalled_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_kind_r) &&
                                    $stable(out_last_r)))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire
